### hw/rtl/shfp_pkg.sv
package shfp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_CMD_HI = 3'd2,
    PH_CMD_LO = 3'd3,
    PH_LEN    = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  localparam logic [7:0] SYNC_FIRST       = 8'hFF;
  localparam logic [7:0] SYNC_SECOND      = 8'h55;
  localparam logic [7:0] VALUE_LEN        = 8'd4;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;

endpackage

### hw/rtl/sync_header_frame_parser_top.sv
// Path: an accepted byte is captured in the input register; a frame result it
// completes is then loaded from there into the result register, raising out_valid.
// Throughput: one byte item per cycle; the result register only stalls the
// input register while a finished result waits for out_ready.
// Reset (rst_n low, synchronous): hunt for the first sync byte, empty stages,
// max_length back to 64.
module sync_header_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_frame_command,
  output logic [7:0]  out_frame_length,
  output logic        out_value_valid,
  output logic [31:0] out_value_bits,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import shfp_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;

  logic [7:0]  max_length_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] command_r, command_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [31:0] payload_r, payload_nxt;
  logic        emit;

  logic        out_valid_r;
  logic [15:0] out_command_r;
  logic [7:0]  out_length_r;
  logic        out_vvalid_r;
  logic [31:0] out_bits_r;

  // Advance the input register whenever the result register can take a slot
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_SYNC1: begin
        if (s1_byte_r == SYNC_FIRST) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (s1_byte_r == SYNC_SECOND) phase_nxt = PH_CMD_HI;
        else if (s1_byte_r != SYNC_FIRST) phase_nxt = PH_SYNC1;
      end
      PH_CMD_HI: phase_nxt = PH_CMD_LO;
      PH_CMD_LO: phase_nxt = PH_LEN;
      PH_LEN: begin
        if (s1_byte_r > max_length_r || s1_byte_r == 8'd0) phase_nxt = PH_SYNC1;
        else phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if ((count_r + 8'd1) >= length_r) phase_nxt = PH_SYNC1;
      end
      default: phase_nxt = PH_SYNC1;
    endcase
  end

  // Frame fields and result strobe
  always_comb begin
    command_nxt = command_r;
    length_nxt  = length_r;
    count_nxt   = count_r;
    payload_nxt = payload_r;
    emit        = 1'b0;
    unique case (phase_r)
      PH_CMD_HI: command_nxt = {s1_byte_r, 8'd0};
      PH_CMD_LO: command_nxt = {command_r[15:8], s1_byte_r};
      PH_LEN: begin
        length_nxt = s1_byte_r;
        if (s1_byte_r <= max_length_r) begin
          count_nxt   = 8'd0;
          payload_nxt = 32'd0;
          emit        = (s1_byte_r == 8'd0);
        end
      end
      PH_DATA: begin
        // keep only the first four payload bytes
        if (count_r < VALUE_LEN) payload_nxt = {payload_r[23:0], s1_byte_r};
        count_nxt = count_r + 8'd1;
        emit      = ((count_r + 8'd1) >= length_r);
      end
      default: ;
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
    end
    if (s1_adv) begin
      command_r <= command_nxt;
      length_r  <= length_nxt;
      count_r   <= count_nxt;
      payload_r <= payload_nxt;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_adv && emit;
    end
    if (s1_adv && emit) begin
      out_command_r <= command_nxt;
      out_length_r  <= length_nxt;
      out_vvalid_r  <= (length_nxt == VALUE_LEN);
      out_bits_r    <= (length_nxt == VALUE_LEN) ? payload_nxt : 32'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_command = out_command_r;
  assign out_frame_length  = out_length_r;
  assign out_value_valid   = out_vvalid_r;
  assign out_value_bits    = out_bits_r;

  // A marked value always belongs to a four-byte frame
  a_vvalid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_valid |-> out_frame_length == VALUE_LEN)
    else $error("value_valid without four-byte length");

  // Unmarked results carry a zero value
  a_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_valid |-> out_value_bits == 32'd0)
    else $error("value_bits nonzero while value_valid low");

  // A stalled input register never moves the parser
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(phase_r))
    else $error("phase changed without an advancing item");

  // Every result follows a frame end back to hunting
  a_emit_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit |=> phase_r == PH_SYNC1)
    else $error("result emitted without return to hunting");

endmodule
